### rtl/ac_tig_weld_sequencer_defines.svh
// ----------------------------------------------------------------------------
// ac tig weld sequencer assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef AC_TIG_WELD_SEQUENCER_DEFINES_SVH
`define AC_TIG_WELD_SEQUENCER_DEFINES_SVH

// same-cycle implication, reset masked
`define ATWS_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("atws check failed");

// next-cycle implication, reset masked
`define ATWS_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("atws check failed");

`endif

### rtl/atws_pkg.sv
// ----------------------------------------------------------------------------
// atws_pkg
// shared types and constants of the ac tig weld sequencer
// ----------------------------------------------------------------------------
package atws_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 8;

	localparam int unsigned DIV_W      = 20;
	localparam int unsigned DIVISOR_W  = 13;
	localparam int unsigned DIV_CNT_W  = $clog2(DIV_W);
	localparam int unsigned MUL_W      = 20;
	localparam int unsigned PROD_W     = 2 * MUL_W;

	// floor(x / 100) = (x * RECIP100) >> RECIP_SHIFT for x below 2**20
	localparam logic [MUL_W-1:0] RECIP100    = 20'd671089;
	localparam int unsigned      RECIP_SHIFT = 26;

	localparam logic [DIV_W-1:0] TICKS_PER_SEC = 20'd100000;
	localparam logic [12:0]      MS_PER_TENTH  = 13'd100;

	localparam logic [6:0] DUTY_MAX_LO  = 7'd10;
	localparam logic [6:0] DUTY_MAX_HI  = 7'd100;
	localparam logic [7:0] FREQ_LO      = 8'd20;
	localparam logic [7:0] FREQ_HI      = 8'd200;
	localparam logic [5:0] BAL_LO       = 6'd10;
	localparam logic [5:0] BAL_HI       = 6'd50;
	localparam logic [5:0] SLOPE_HI     = 6'd50;
	localparam logic [6:0] HOT_HI       = 7'd100;

	localparam logic [6:0]  DUTY_MAX_RST = 7'd80;
	localparam logic [7:0]  FREQ_RST     = 8'd100;
	localparam logic [5:0]  BAL_RST      = 6'd30;
	localparam logic [12:0] UP_MS_RST    = 13'd1000;
	localparam logic [12:0] DN_MS_RST    = 13'd2000;
	localparam logic [6:0]  HOT_RST      = 7'd20;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DUTY_MAX,
		CFG_AC_FREQ,
		CFG_BALANCE,
		CFG_UP_SLOPE,
		CFG_DOWN_SLOPE,
		CFG_HOT_START
	} cfg_idx_t;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_END,
		MODE_DOWN,
		MODE_UP,
		MODE_STEADY
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TOT,
		ST_TOT_W,
		ST_CYC,
		ST_EPP,
		ST_EPR,
		ST_PLAN,
		ST_DMUL,
		ST_DIV,
		ST_DIV_W,
		ST_DUTY,
		ST_EPON1,
		ST_EPON2,
		ST_ENON1,
		ST_ENON2,
		ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_DIV_TOT,
		OP_MUL_CYC,
		OP_MUL_EPP,
		OP_MUL_EPR,
		OP_PLAN,
		OP_MUL_DMAX,
		OP_DIV_DUTY,
		OP_DUTY,
		OP_MUL_EP,
		OP_RECIP_EP,
		OP_MUL_EN,
		OP_RECIP_EN,
		OP_LOAD_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic  div_done;
		mode_t mode;
	} dp_sts_t;

	typedef struct packed {
		logic        period_valid;
		logic [6:0]  preheat_ms;
		logic [11:0] ep_on_time;
		logic [11:0] ep_off_time;
		logic [12:0] en_on_time;
		logic [12:0] en_off_time;
		logic [6:0]  duty_pct;
		logic        weld_done;
	} res_t;

endpackage

### rtl/atws_in_if.sv
// ----------------------------------------------------------------------------
// atws_in_if
// trigger channel: one transaction per ac period or idle poll
// ----------------------------------------------------------------------------
interface atws_in_if;
	logic valid;
	logic ready;
	logic weld_request;

	modport source (output valid, output weld_request, input ready);
	modport sink (input valid, input weld_request, output ready);
endinterface

### rtl/atws_out_if.sv
// ----------------------------------------------------------------------------
// atws_out_if
// schedule channel: one transaction per accepted trigger transaction
// ----------------------------------------------------------------------------
interface atws_out_if;
	logic        valid;
	logic        ready;
	logic        period_valid;
	logic [6:0]  preheat_ms;
	logic [11:0] ep_on_time;
	logic [11:0] ep_off_time;
	logic [12:0] en_on_time;
	logic [12:0] en_off_time;
	logic [6:0]  duty_pct;
	logic        weld_done;

	modport source (
		output valid, output period_valid, output preheat_ms, output ep_on_time,
		output ep_off_time, output en_on_time, output en_off_time, output duty_pct,
		output weld_done, input ready
	);
	modport sink (
		input valid, input period_valid, input preheat_ms, input ep_on_time,
		input ep_off_time, input en_on_time, input en_off_time, input duty_pct,
		input weld_done, output ready
	);
endinterface

### rtl/ac_tig_weld_sequencer.sv
// ----------------------------------------------------------------------------
// ac_tig_weld_sequencer
// ac tig weld sequencer: hot start, up slope, steady, down slope, period split
// ----------------------------------------------------------------------------
// trig carries one transaction per ac period or idle poll with the trigger
// level; sched returns exactly one transaction for each, in order.
// settings are written through cfg_we / cfg_index / cfg_data and are clamped
// into range as they are stored; the user must write them only while idle,
// as the block itself does not enforce it. each transaction runs from the
// cycle trig is accepted until trig is ready again; an idle poll or a weld
// end skips the duty and split steps and steady duty skips the divide. the
// shared 20-step restoring divider serves the period from frequency and the
// slope duty, and the single shared multiplier is used for the on/off split.
// trig is ready only while no transaction is being worked on; a finished
// result sits in the sched register so the next trigger transaction can be
// taken while the receiver stalls. a new result waits until sched is free.
// reset clears the weld state, restores the default settings and drops
// sched valid; the result register itself has no reset.
// ----------------------------------------------------------------------------
module ac_tig_weld_sequencer (
	input  logic                                clk,
	input  logic                                arst_n,
	atws_in_if.sink                             trig,
	atws_out_if.source                          sched,
	input  logic                                cfg_we,
	input  logic [atws_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [atws_pkg::CFG_DATA_W-1:0]     cfg_data
);

	atws_pkg::dp_cmd_t cmd;
	atws_pkg::dp_sts_t sts;
	atws_pkg::res_t    res;

	atws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (trig.valid),
		.in_ready  (trig.ready),
		.out_valid (sched.valid),
		.out_ready (sched.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	atws_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (trig.weld_request),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res       (res)
	);

	assign sched.period_valid = res.period_valid;
	assign sched.preheat_ms   = res.preheat_ms;
	assign sched.ep_on_time   = res.ep_on_time;
	assign sched.ep_off_time  = res.ep_off_time;
	assign sched.en_on_time   = res.en_on_time;
	assign sched.en_off_time  = res.en_off_time;
	assign sched.duty_pct     = res.duty_pct;
	assign sched.weld_done    = res.weld_done;

endmodule

### rtl/atws_div.sv
// ----------------------------------------------------------------------------
// atws_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module atws_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [atws_pkg::DIV_W-1:0]         dividend,
	input  logic [atws_pkg::DIVISOR_W-1:0]     divisor,
	output logic                               done,
	output logic [atws_pkg::DIV_W-1:0]         quotient
);

	logic                               busy_q;
	logic [atws_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [atws_pkg::DIVISOR_W-1:0]     rem_q;
	logic [atws_pkg::DIV_W-1:0]         quo_q;
	logic [atws_pkg::DIVISOR_W-1:0]     dvs_q;
	logic [atws_pkg::DIVISOR_W:0]       trial;
	logic [atws_pkg::DIVISOR_W:0]       diff;
	logic                               ge;

	assign trial = {rem_q, quo_q[atws_pkg::DIV_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= atws_pkg::DIV_CNT_W'(atws_pkg::DIV_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[atws_pkg::DIVISOR_W-1:0] : trial[atws_pkg::DIVISOR_W-1:0];
			quo_q <= {quo_q[atws_pkg::DIV_W-2:0], ge};
		end
	end

	assign done     = busy_q && (cnt_q == '0);
	assign quotient = quo_q;

endmodule

### rtl/atws_dp.sv
// ----------------------------------------------------------------------------
// atws_dp
// datapath: settings, weld state, shared multiplier, divider and result register
// ----------------------------------------------------------------------------
module atws_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  atws_pkg::dp_cmd_t                   cmd,
	output atws_pkg::dp_sts_t                   sts,
	input  logic                                req,
	input  logic                                cfg_we,
	input  logic [atws_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [atws_pkg::CFG_DATA_W-1:0]     cfg_data,
	output atws_pkg::res_t                      res
);

	// settings, stored already clamped
	logic [6:0]  dmax_q;
	logic [7:0]  freq_q;
	logic [5:0]  bal_q;
	logic [12:0] up_ms_q;
	logic [12:0] dn_ms_q;
	logic [6:0]  hot_q;

	logic [6:0]  cfg_dmax;
	logic [7:0]  cfg_hz;
	logic [5:0]  cfg_bal;
	logic [5:0]  cfg_up_t;
	logic [5:0]  cfg_dn_t;
	logic [6:0]  cfg_hot;

	// weld state
	logic        welding_q;
	logic        ds_q;
	logic [12:0] elapsed_q;

	// working registers
	logic                          req_q;
	logic [12:0]                   t_tot_q;
	logic [5:0]                    cycle_q;
	logic [11:0]                   t_ep_q;
	logic [12:0]                   t_en_q;
	atws_pkg::mode_t               mode_q;
	logic [13:0]                   e1_q;
	logic [6:0]                    preheat_q;
	logic [6:0]                    duty_q;
	logic [11:0]                   ep_on_q;
	logic [atws_pkg::PROD_W-1:0]   p_q;
	atws_pkg::res_t                res_q;

	// plan
	logic            start_c;
	logic            rel_c;
	logic            ds0;
	logic [12:0]     e0;
	logic [13:0]     sum_c;
	logic [13:0]     e1_c;
	atws_pkg::mode_t mode_c;

	// shared units
	logic [atws_pkg::MUL_W-1:0]      mul_a;
	logic [atws_pkg::MUL_W-1:0]      mul_b;
	logic                            mul_en;
	logic [atws_pkg::PROD_W-1:0]     prod_c;
	logic                            div_start;
	logic [atws_pkg::DIV_W-1:0]      div_dividend;
	logic [atws_pkg::DIVISOR_W-1:0]  div_divisor;
	logic                            div_done;
	logic [atws_pkg::DIV_W-1:0]      div_quo;

	logic [6:0]  duty_c;
	logic [12:0] en_on_c;

	always_comb begin
		cfg_dmax = cfg_data[6:0];
		if (cfg_data[6:0] < atws_pkg::DUTY_MAX_LO) cfg_dmax = atws_pkg::DUTY_MAX_LO;
		if (cfg_data[6:0] > atws_pkg::DUTY_MAX_HI) cfg_dmax = atws_pkg::DUTY_MAX_HI;
		cfg_hz = cfg_data;
		if (cfg_data < atws_pkg::FREQ_LO) cfg_hz = atws_pkg::FREQ_LO;
		if (cfg_data > atws_pkg::FREQ_HI) cfg_hz = atws_pkg::FREQ_HI;
		cfg_bal = cfg_data[5:0];
		if (cfg_data[5:0] < atws_pkg::BAL_LO) cfg_bal = atws_pkg::BAL_LO;
		if (cfg_data[5:0] > atws_pkg::BAL_HI) cfg_bal = atws_pkg::BAL_HI;
		cfg_up_t = (cfg_data[5:0] > atws_pkg::SLOPE_HI) ? atws_pkg::SLOPE_HI : cfg_data[5:0];
		cfg_dn_t = cfg_up_t;
		cfg_hot  = (cfg_data[6:0] > atws_pkg::HOT_HI) ? atws_pkg::HOT_HI : cfg_data[6:0];
	end

	// release and start decisions, mode and elapsed time for this transaction
	always_comb begin
		start_c = !welding_q && req_q;
		rel_c   = welding_q && !req_q && !ds_q;
		ds0     = ds_q;
		e0      = elapsed_q;
		if (start_c || rel_c) e0 = '0;
		if (start_c) begin
			ds0 = 1'b0;
		end else if (rel_c) begin
			ds0 = 1'b1;
		end
		sum_c  = {1'b0, e0} + 14'(cycle_q);
		e1_c   = {1'b0, e0};
		mode_c = atws_pkg::MODE_STEADY;
		priority if (!welding_q && !req_q) begin
			mode_c = atws_pkg::MODE_IDLE;
		end else if (rel_c && (dn_ms_q == '0)) begin
			mode_c = atws_pkg::MODE_END;
		end else if (ds0) begin
			e1_c   = sum_c;
			mode_c = (sum_c >= {1'b0, dn_ms_q}) ? atws_pkg::MODE_END : atws_pkg::MODE_DOWN;
		end else if (e0 < up_ms_q) begin
			e1_c   = sum_c;
			mode_c = atws_pkg::MODE_UP;
		end else begin
			mode_c = atws_pkg::MODE_STEADY;
		end
	end

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		unique case (cmd.op)
			atws_pkg::OP_MUL_CYC: begin
				mul_a = div_quo;
				mul_b = atws_pkg::RECIP100;
			end
			atws_pkg::OP_MUL_EPP: begin
				mul_a = 20'(t_tot_q);
				mul_b = 20'(bal_q);
			end
			atws_pkg::OP_MUL_EPR, atws_pkg::OP_RECIP_EP, atws_pkg::OP_RECIP_EN: begin
				mul_a = p_q[atws_pkg::MUL_W-1:0];
				mul_b = atws_pkg::RECIP100;
			end
			atws_pkg::OP_MUL_DMAX: begin
				mul_a = 20'(dmax_q);
				mul_b = 20'(e1_q);
			end
			atws_pkg::OP_MUL_EP: begin
				mul_a = 20'(t_ep_q);
				mul_b = 20'(duty_q);
			end
			atws_pkg::OP_MUL_EN: begin
				mul_a = 20'(t_en_q);
				mul_b = 20'(duty_q);
			end
			default: mul_en = 1'b0;
		endcase
	end

	assign prod_c = mul_a * mul_b;

	assign div_start    = (cmd.op == atws_pkg::OP_DIV_TOT) || (cmd.op == atws_pkg::OP_DIV_DUTY);
	assign div_dividend = (cmd.op == atws_pkg::OP_DIV_TOT) ? atws_pkg::TICKS_PER_SEC
		: p_q[atws_pkg::DIV_W-1:0];
	assign div_divisor  = (cmd.op == atws_pkg::OP_DIV_TOT) ? 13'(freq_q)
		: ((mode_q == atws_pkg::MODE_DOWN) ? dn_ms_q : up_ms_q);

	atws_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		unique case (mode_q)
			atws_pkg::MODE_DOWN: duty_c = dmax_q - div_quo[6:0];
			atws_pkg::MODE_UP:   duty_c = (div_quo > 20'(dmax_q)) ? dmax_q : div_quo[6:0];
			default:             duty_c = dmax_q;
		endcase
	end

	assign en_on_c = p_q[atws_pkg::RECIP_SHIFT +: 13];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dmax_q    <= atws_pkg::DUTY_MAX_RST;
			freq_q    <= atws_pkg::FREQ_RST;
			bal_q     <= atws_pkg::BAL_RST;
			up_ms_q   <= atws_pkg::UP_MS_RST;
			dn_ms_q   <= atws_pkg::DN_MS_RST;
			hot_q     <= atws_pkg::HOT_RST;
			welding_q <= 1'b0;
			ds_q      <= 1'b0;
			elapsed_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					atws_pkg::CFG_DUTY_MAX:   dmax_q  <= cfg_dmax;
					atws_pkg::CFG_AC_FREQ:    freq_q  <= cfg_hz;
					atws_pkg::CFG_BALANCE:    bal_q   <= cfg_bal;
					atws_pkg::CFG_UP_SLOPE:   up_ms_q <= 13'(cfg_up_t) * atws_pkg::MS_PER_TENTH;
					atws_pkg::CFG_DOWN_SLOPE: dn_ms_q <= 13'(cfg_dn_t) * atws_pkg::MS_PER_TENTH;
					atws_pkg::CFG_HOT_START:  hot_q   <= cfg_hot;
					default: ;
				endcase
			end
			if (cmd.op == atws_pkg::OP_PLAN) begin
				unique case (mode_c)
					atws_pkg::MODE_IDLE: ;
					atws_pkg::MODE_END: begin
						welding_q <= 1'b0;
						ds_q      <= 1'b0;
						elapsed_q <= '0;
					end
					default: begin
						welding_q <= 1'b1;
						ds_q      <= ds0;
						elapsed_q <= e1_c[12:0];
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mul_en) p_q <= prod_c;
		unique case (cmd.op)
			atws_pkg::OP_CAPTURE: req_q <= req;
			atws_pkg::OP_MUL_CYC: t_tot_q <= div_quo[12:0];
			atws_pkg::OP_MUL_EPP: cycle_q <= p_q[atws_pkg::RECIP_SHIFT +: 6];
			atws_pkg::OP_PLAN: begin
				t_ep_q    <= p_q[atws_pkg::RECIP_SHIFT +: 12];
				mode_q    <= mode_c;
				e1_q      <= e1_c;
				preheat_q <= start_c ? hot_q : 7'd0;
			end
			atws_pkg::OP_MUL_DMAX: t_en_q <= t_tot_q - 13'(t_ep_q);
			atws_pkg::OP_DUTY: duty_q <= duty_c;
			atws_pkg::OP_MUL_EN: ep_on_q <= p_q[atws_pkg::RECIP_SHIFT +: 12];
			atws_pkg::OP_LOAD_OUT: begin
				res_q <= '0;
				unique case (mode_q)
					atws_pkg::MODE_IDLE: ;
					atws_pkg::MODE_END: res_q.weld_done <= 1'b1;
					default: begin
						res_q.period_valid <= 1'b1;
						res_q.preheat_ms   <= preheat_q;
						res_q.ep_on_time   <= ep_on_q;
						res_q.ep_off_time  <= t_ep_q - ep_on_q;
						res_q.en_on_time   <= en_on_c;
						res_q.en_off_time  <= t_en_q - en_on_c;
						res_q.duty_pct     <= duty_q;
					end
				endcase
			end
			default: ;
		endcase
	end

	assign sts.div_done = div_done;
	assign sts.mode     = mode_q;
	assign res          = res_q;

endmodule

### rtl/atws_ctrl.sv
// ----------------------------------------------------------------------------
// atws_ctrl
// sequencing state machine and output handshake
// ----------------------------------------------------------------------------
module atws_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output atws_pkg::dp_cmd_t  cmd,
	input  atws_pkg::dp_sts_t  sts
);

	atws_pkg::state_t state_q;
	atws_pkg::state_t state_nxt;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= atws_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.op == atws_pkg::OP_LOAD_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd.op    = atws_pkg::OP_NONE;
		in_ready  = 1'b0;
		unique case (state_q)
			atws_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op    = atws_pkg::OP_CAPTURE;
					state_nxt = atws_pkg::ST_TOT;
				end
			end
			atws_pkg::ST_TOT: begin
				cmd.op    = atws_pkg::OP_DIV_TOT;
				state_nxt = atws_pkg::ST_TOT_W;
			end
			atws_pkg::ST_TOT_W: begin
				if (sts.div_done) state_nxt = atws_pkg::ST_CYC;
			end
			atws_pkg::ST_CYC: begin
				cmd.op    = atws_pkg::OP_MUL_CYC;
				state_nxt = atws_pkg::ST_EPP;
			end
			atws_pkg::ST_EPP: begin
				cmd.op    = atws_pkg::OP_MUL_EPP;
				state_nxt = atws_pkg::ST_EPR;
			end
			atws_pkg::ST_EPR: begin
				cmd.op    = atws_pkg::OP_MUL_EPR;
				state_nxt = atws_pkg::ST_PLAN;
			end
			atws_pkg::ST_PLAN: begin
				cmd.op    = atws_pkg::OP_PLAN;
				state_nxt = atws_pkg::ST_DMUL;
			end
			atws_pkg::ST_DMUL: begin
				cmd.op = atws_pkg::OP_MUL_DMAX;
				unique case (sts.mode)
					atws_pkg::MODE_UP, atws_pkg::MODE_DOWN: state_nxt = atws_pkg::ST_DIV;
					atws_pkg::MODE_STEADY:                  state_nxt = atws_pkg::ST_DUTY;
					default:                                state_nxt = atws_pkg::ST_OUT;
				endcase
			end
			atws_pkg::ST_DIV: begin
				cmd.op    = atws_pkg::OP_DIV_DUTY;
				state_nxt = atws_pkg::ST_DIV_W;
			end
			atws_pkg::ST_DIV_W: begin
				if (sts.div_done) state_nxt = atws_pkg::ST_DUTY;
			end
			atws_pkg::ST_DUTY: begin
				cmd.op    = atws_pkg::OP_DUTY;
				state_nxt = atws_pkg::ST_EPON1;
			end
			atws_pkg::ST_EPON1: begin
				cmd.op    = atws_pkg::OP_MUL_EP;
				state_nxt = atws_pkg::ST_EPON2;
			end
			atws_pkg::ST_EPON2: begin
				cmd.op    = atws_pkg::OP_RECIP_EP;
				state_nxt = atws_pkg::ST_ENON1;
			end
			atws_pkg::ST_ENON1: begin
				cmd.op    = atws_pkg::OP_MUL_EN;
				state_nxt = atws_pkg::ST_ENON2;
			end
			atws_pkg::ST_ENON2: begin
				cmd.op    = atws_pkg::OP_RECIP_EN;
				state_nxt = atws_pkg::ST_OUT;
			end
			atws_pkg::ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.op    = atws_pkg::OP_LOAD_OUT;
					state_nxt = atws_pkg::ST_IDLE;
				end
			end
			default: state_nxt = atws_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/atws_chk.sv
// ----------------------------------------------------------------------------
// atws_chk
// port checker for the schedule channel, bound to the top level
// ----------------------------------------------------------------------------
`include "ac_tig_weld_sequencer_defines.svh"

module atws_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        period_valid,
	input logic [6:0]  preheat_ms,
	input logic [11:0] ep_on_time,
	input logic [11:0] ep_off_time,
	input logic [12:0] en_on_time,
	input logic [12:0] en_off_time,
	input logic [6:0]  duty_pct,
	input logic        weld_done
);

	`ATWS_ASSERT_NXT(a_valid_hold, out_valid && !out_ready, out_valid)
	`ATWS_ASSERT_NXT(a_payload_hold, out_valid && !out_ready, $stable(period_valid) && $stable(preheat_ms) && $stable(ep_on_time) && $stable(ep_off_time) && $stable(en_on_time) && $stable(en_off_time) && $stable(duty_pct) && $stable(weld_done))
	`ATWS_ASSERT_IMP(a_done_excl, out_valid, !(period_valid && weld_done))
	`ATWS_ASSERT_IMP(a_preheat_period, out_valid && (preheat_ms != 7'd0), period_valid)
	`ATWS_ASSERT_IMP(a_no_period_zero, out_valid && !period_valid, (duty_pct == 7'd0) && (ep_on_time == 12'd0) && (ep_off_time == 12'd0) && (en_on_time == 13'd0) && (en_off_time == 13'd0))

endmodule

bind ac_tig_weld_sequencer atws_chk u_atws_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (sched.valid),
	.out_ready    (sched.ready),
	.period_valid (sched.period_valid),
	.preheat_ms   (sched.preheat_ms),
	.ep_on_time   (sched.ep_on_time),
	.ep_off_time  (sched.ep_off_time),
	.en_on_time   (sched.en_on_time),
	.en_off_time  (sched.en_off_time),
	.duty_pct     (sched.duty_pct),
	.weld_done    (sched.weld_done)
);

### test/tb_ac_tig_weld_sequencer.sv
// ----------------------------------------------------------------------------
// tb_ac_tig_weld_sequencer
// self-checking bench for the ac tig weld sequencer: trigger transactions go
// in from a queue under random gaps, every schedule transaction is predicted
// in the bench (hot start, up slope, steady, down slope, ep/en split) and
// compared field by field; settings change between phases, extremes included
// ----------------------------------------------------------------------------
module tb_ac_tig_weld_sequencer;

	localparam int unsigned STALL_LIMIT = 5000;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [atws_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [atws_pkg::CFG_DATA_W-1:0] cfg_data;

	atws_in_if  trig_if ();
	atws_out_if sched_if ();

	ac_tig_weld_sequencer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.trig      (trig_if),
		.sched     (sched_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// bench copy of the settings and weld state
	int unsigned cfg_duty_max = 80;
	int unsigned set_hz       = 100;
	int unsigned set_bal      = 30;
	int unsigned cfg_up       = 10;
	int unsigned cfg_down     = 20;
	int unsigned cfg_hot      = 20;
	bit          welding      = 1'b0;
	bit          in_down      = 1'b0;
	int unsigned weld_ms      = 0;

	bit               trigger_queue[$];
	atws_pkg::res_t   schedule_due[$];
	int unsigned open_items  = 0;
	int unsigned sent_items  = 0;
	int unsigned errors      = 0;
	int unsigned stall_cycles = 0;
	bit          calm        = 1'b0;

	always #10 clk = ~clk;

	function automatic int unsigned sat(input int unsigned v, input int unsigned lo,
		input int unsigned hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// next schedule for one trigger transaction, advances the weld state
	function automatic atws_pkg::res_t weld_schedule(input logic req);
		int unsigned dmax, freq, bal, up_ms, dn_ms, hot, cyc_ms;
		int unsigned t_tot, t_ep, t_en, duty, ep_on, en_on, heat;
		atws_pkg::res_t r;
		dmax   = sat(cfg_duty_max, 10, 100);
		freq   = sat(set_hz, 20, 200);
		bal    = sat(set_bal, 10, 50);
		up_ms  = sat(cfg_up, 0, 50) * 100;
		dn_ms  = sat(cfg_down, 0, 50) * 100;
		hot    = sat(cfg_hot, 0, 100);
		cyc_ms = 1000 / freq;
		t_tot  = 100000 / freq;
		t_ep   = (t_tot * bal) / 100;
		t_en   = t_tot - t_ep;
		heat   = 0;
		r      = '0;
		if (!welding) begin
			if (!req)
				return r;
			welding = 1'b1;
			in_down = 1'b0;
			weld_ms = 0;
			heat    = hot;
		end else if (!req && !in_down) begin
			if (dn_ms == 0) begin
				welding     = 1'b0;
				weld_ms     = 0;
				r.weld_done = 1'b1;
				return r;
			end
			in_down = 1'b1;
			weld_ms = 0;
		end
		if (in_down) begin
			weld_ms += cyc_ms;
			if (weld_ms >= dn_ms) begin
				welding     = 1'b0;
				in_down     = 1'b0;
				weld_ms     = 0;
				r.weld_done = 1'b1;
				return r;
			end
			duty = dmax - (dmax * weld_ms) / dn_ms;
		end else if (weld_ms < up_ms) begin
			weld_ms += cyc_ms;
			duty = (dmax * weld_ms) / up_ms;
			if (duty > dmax)
				duty = dmax;
		end else begin
			duty = dmax;
		end
		weld_ms &= 32'h1fff;
		ep_on = (t_ep * duty) / 100;
		en_on = (t_en * duty) / 100;
		r.period_valid = 1'b1;
		r.preheat_ms   = 7'(heat);
		r.ep_on_time   = 12'(ep_on);
		r.ep_off_time  = 12'(t_ep - ep_on);
		r.en_on_time   = 13'(en_on);
		r.en_off_time  = 13'(t_en - en_on);
		r.duty_pct     = 7'(duty);
		return r;
	endfunction

	function automatic int unsigned pick_setting(input int unsigned w, input int unsigned lo,
		input int unsigned hi);
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 15) return lo;
		if (roll < 30) return hi;
		if (roll < 40) return $urandom_range((1 << w) - 1);
		return $urandom_range(hi, lo);
	endfunction

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	task automatic push_trigger(input bit level);
		trigger_queue.push_back(level);
		open_items++;
		sent_items++;
	endtask

	task automatic write_setting(input atws_pkg::cfg_idx_t idx, input int unsigned value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[7:0];
		unique case (idx)
			atws_pkg::CFG_DUTY_MAX:   cfg_duty_max = value & 32'h7f;
			atws_pkg::CFG_AC_FREQ:    set_hz       = value & 32'hff;
			atws_pkg::CFG_BALANCE:    set_bal      = value & 32'h3f;
			atws_pkg::CFG_UP_SLOPE:   cfg_up       = value & 32'h3f;
			atws_pkg::CFG_DOWN_SLOPE: cfg_down     = value & 32'h3f;
			atws_pkg::CFG_HOT_START:  cfg_hot      = value & 32'h7f;
			default: ;
		endcase
	endtask

	task automatic program_settings(input int unsigned duty_max, input int unsigned freq,
		input int unsigned balance, input int unsigned up, input int unsigned down,
		input int unsigned hot);
		write_setting(atws_pkg::CFG_DUTY_MAX, duty_max);
		write_setting(atws_pkg::CFG_AC_FREQ, freq);
		write_setting(atws_pkg::CFG_BALANCE, balance);
		write_setting(atws_pkg::CFG_UP_SLOPE, up);
		write_setting(atws_pkg::CFG_DOWN_SLOPE, down);
		write_setting(atws_pkg::CFG_HOT_START, hot);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (open_items != 0)
			@(posedge clk);
	endtask

	// trigger driver
	always @(posedge clk) begin
		if (!arst_n) begin
			trig_if.valid <= 1'b0;
		end else begin
			if (trig_if.valid && trig_if.ready)
				schedule_due.push_back(weld_schedule(trig_if.weld_request));
			if (!trig_if.valid || trig_if.ready) begin
				if (trigger_queue.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
					trig_if.valid        <= 1'b1;
					trig_if.weld_request <= trigger_queue.pop_front();
				end else begin
					trig_if.valid <= 1'b0;
				end
			end
		end
	end

	// schedule monitor
	always @(posedge clk) begin : sched_mon
		atws_pkg::res_t want;
		if (!arst_n) begin
			sched_if.ready <= 1'b0;
		end else begin
			sched_if.ready <= calm || ($urandom_range(99) >= 20);
			if (sched_if.valid && sched_if.ready) begin
				if (schedule_due.size() == 0) begin
					$error("schedule transaction with nothing expected");
					errors++;
				end else begin
					want = schedule_due.pop_front();
					check_field("period_valid", want.period_valid, sched_if.period_valid);
					check_field("preheat_ms", want.preheat_ms, sched_if.preheat_ms);
					check_field("ep_on_time", want.ep_on_time, sched_if.ep_on_time);
					check_field("ep_off_time", want.ep_off_time, sched_if.ep_off_time);
					check_field("en_on_time", want.en_on_time, sched_if.en_on_time);
					check_field("en_off_time", want.en_off_time, sched_if.en_off_time);
					check_field("duty_pct", want.duty_pct, sched_if.duty_pct);
					check_field("weld_done", want.weld_done, sched_if.weld_done);
					open_items--;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((trig_if.valid && trig_if.ready) || (sched_if.valid && sched_if.ready))
			stall_cycles <= 0;
		else if (open_items != 0)
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int unsigned n, k, hold, rel, roll;
		clk                  = 1'b0;
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = atws_pkg::CFG_DUTY_MAX;
		cfg_data             = '0;
		trig_if.valid        = 1'b0;
		trig_if.weld_request = 1'b0;
		sched_if.ready       = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default settings: idle polls, weld start, up slope, release, trigger in down slope
		push_trigger(1'b0);
		push_trigger(1'b0);
		push_trigger(1'b1);
		push_trigger(1'b1);
		push_trigger(1'b1);
		push_trigger(1'b0);
		push_trigger(1'b1);
		wait_drained();

		// out-of-range settings saturate; zero down slope ends the weld at release
		program_settings(127, 0, 63, 1, 0, 127);
		push_trigger(1'b1);
		push_trigger(1'b1);
		push_trigger(1'b1);
		push_trigger(1'b1);
		push_trigger(1'b1);
		push_trigger(1'b0);
		wait_drained();

		// opposite extremes, long slopes, no hot start
		program_settings(0, 255, 0, 63, 63, 0);
		push_trigger(1'b1);
		push_trigger(1'b1);
		push_trigger(1'b0);
		push_trigger(1'b0);
		push_trigger(1'b1);
		push_trigger(1'b0);
		wait_drained();

		while (sent_items < 1400) begin
			calm = (sent_items >= 500 && sent_items < 800);
			program_settings(
				pick_setting(7, 10, 100),
				pick_setting(8, 20, 200),
				pick_setting(6, 10, 50),
				($urandom_range(99) < 60) ? $urandom_range(5) : pick_setting(6, 0, 50),
				($urandom_range(99) < 60) ? $urandom_range(5) : pick_setting(6, 0, 50),
				pick_setting(7, 0, 100));
			n = $urandom_range(140, 40);
			k = 0;
			while (k < n) begin
				roll = $urandom_range(99);
				if (roll < 10) begin
					push_trigger(1'($urandom_range(1)));
					k++;
				end else begin
					hold = $urandom_range(25, 1);
					rel  = $urandom_range(25, 1);
					repeat (hold) push_trigger(1'b1);
					repeat (rel) push_trigger($urandom_range(99) < 10);
					k += hold + rel;
				end
			end
			wait_drained();
		end
		calm = 1'b0;

		wait_drained();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
